// ===== design/pldg_pkg.sv =====
package pldg_pkg;

    localparam int MAX_POINTS   = 128;
    localparam int IDX_W        = 7;
    localparam int RESET_POINTS = 72;
    localparam int FREQ_W       = 20;
    localparam int GAIN_W       = 16;

    // wide multiplier, built from four 23x23 partial products
    localparam int MUL_W  = 46;
    localparam int HALF_W = 23;
    localparam int PROD_W = 92;

    // mantissa of 10^(r/2560) is Q6.40, reciprocal decades are Q.48
    localparam int FRAC_W       = 40;
    localparam int RECIP_FRAC_W = 48;
    localparam int OUT_FRAC_W   = 16;

    localparam int DIV_STEPS = 17;
    localparam int EXP_BITS  = 12;
    localparam int Q_OFFSET  = 13;
    localparam int Q_RECIP   = 104858;  // ceil(2^28 / 2560)
    localparam int Q_SHIFT   = 28;
    localparam int Q_SAT     = 18;      // decade index at which output always clips

    localparam int INIT_FREQ [RESET_POINTS] = '{
        2560, 4437, 5564, 6690, 8192, 10445, 11947, 16452, 20582, 28092,
        37854, 53248, 64512, 66014, 71270, 78404, 87040, 95300, 103936, 110319,
        115576, 119330, 121958, 124211, 126464, 128341, 129468, 132096, 135475, 138104,
        140356, 142609, 144486, 145988, 147490, 148992, 150118, 151620, 154624, 156877,
        159880, 162884, 165512, 168516, 173022, 177528, 182033, 183535, 185412, 186163,
        187290, 188792, 191420, 194048, 198178, 201557, 206814, 215450, 218078, 221082,
        225587, 228591, 230844, 233096, 235725, 238353, 240606, 242483, 243610, 246613,
        250744, 256000
    };

    localparam int INIT_GAIN [RESET_POINTS] = '{
        1816, 2649, 2983, 5093, 7703, 10147, 10703, 10871, 10871, 10873,
        10653, 10490, 10326, 10104, 9494, 8552, 7665, 6834, 5947, 5171,
        4228, 3563, 3064, 2564, 2232, 2121, 2121, 2177, 2178, 2012,
        1679, 1236, 736, 237, -374, -929, -1206, -1150, -983, -927,
        -982, -1148, -1314, -1369, -1312, -1422, -1976, -2531, -3142, -3586,
        -2919, -2197, -1697, -1419, -1195, -917, -749, -803, -802, -1024,
        -1301, -1355, -1355, -1521, -1465, -1686, -1686, -1797, -1907, -1851,
        -1850, -1683
    };

    typedef struct packed {
        logic [FREQ_W-1:0]        freq;
        logic signed [GAIN_W-1:0] gain;
    } t_point;

    typedef struct packed {
        logic load;
        logic shift;
    } t_cell_ctl;

    typedef struct packed {
        logic             start;
        logic [MUL_W-1:0] a;
        logic [MUL_W-1:0] b;
    } t_mul_req;

    typedef struct packed {
        logic              busy;
        logic              done;
        logic [PROD_W-1:0] p;
    } t_mul_rsp;

    function automatic t_point init_point(int i);
        t_point p;
        p = '0;
        if (i < RESET_POINTS) begin
            p.freq = FREQ_W'(INIT_FREQ[i]);
            p.gain = GAIN_W'(INIT_GAIN[i]);
        end
        return p;
    endfunction

    // 10^(2^j / 2560) in Q6.40
    function automatic logic [MUL_W-1:0] exp_fact(int j);
        real x;
        x = $pow(10.0, (2.0 ** j) / 2560.0) * (2.0 ** FRAC_W);
        return MUL_W'(longint'(x));
    endfunction

    // 10^-k in Q.48
    function automatic logic [MUL_W-1:0] recip_dec(int k);
        real x;
        x = $pow(10.0, -1.0 * k) * (2.0 ** RECIP_FRAC_W);
        return MUL_W'(longint'(x));
    endfunction

    localparam logic [MUL_W-1:0] EXP_FACT [16] = '{
        exp_fact(0), exp_fact(1), exp_fact(2), exp_fact(3),
        exp_fact(4), exp_fact(5), exp_fact(6), exp_fact(7),
        exp_fact(8), exp_fact(9), exp_fact(10), exp_fact(11),
        '0, '0, '0, '0
    };

    localparam logic [MUL_W-1:0] RECIP_DEC [Q_OFFSET] = '{
        recip_dec(1), recip_dec(2), recip_dec(3), recip_dec(4), recip_dec(5),
        recip_dec(6), recip_dec(7), recip_dec(8), recip_dec(9), recip_dec(10),
        recip_dec(11), recip_dec(12), recip_dec(13)
    };

    localparam logic [MUL_W-1:0] POW10 [5] = '{
        MUL_W'(1), MUL_W'(10), MUL_W'(100), MUL_W'(1000), MUL_W'(10000)
    };

endpackage

// ===== design/pldg_cell.sv =====
module pldg_cell (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  pldg_pkg::t_point    i_init,
    input  logic                i_wr,
    input  pldg_pkg::t_point    i_wr_point,
    input  pldg_pkg::t_cell_ctl i_ctl,
    input  pldg_pkg::t_point    i_next,
    output pldg_pkg::t_point    o_scan
);

    pldg_pkg::t_point r_point;
    pldg_pkg::t_point r_scan;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_point <= i_init;
        end else if (i_wr) begin
            r_point <= i_wr_point;
        end
    end

    // scan copy: load own point, then advance toward cell zero
    always_ff @(posedge i_clk) begin
        if (i_ctl.load) begin
            r_scan <= r_point;
        end else if (i_ctl.shift) begin
            r_scan <= i_next;
        end
    end

    assign o_scan = r_scan;

endmodule

// ===== design/pldg_mul.sv =====
module pldg_mul (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  pldg_pkg::t_mul_req i_req,
    output pldg_pkg::t_mul_rsp o_rsp
);

    logic                          r_busy;
    logic                          r_done;
    logic                          r_pend;
    logic [2:0]                    r_cnt;
    logic [1:0]                    r_sel;
    logic [pldg_pkg::MUL_W-1:0]    r_a;
    logic [pldg_pkg::MUL_W-1:0]    r_b;
    logic [pldg_pkg::MUL_W-1:0]    r_pp;
    logic [pldg_pkg::PROD_W-1:0]   r_acc;

    logic [pldg_pkg::HALF_W-1:0]   w_ah;
    logic [pldg_pkg::HALF_W-1:0]   w_bh;
    logic [pldg_pkg::MUL_W-1:0]    w_pp;
    logic [pldg_pkg::PROD_W-1:0]   w_pp_sh;

    assign w_ah = r_cnt[1] ? r_a[pldg_pkg::MUL_W-1:pldg_pkg::HALF_W]
                           : r_a[pldg_pkg::HALF_W-1:0];
    assign w_bh = r_cnt[0] ? r_b[pldg_pkg::MUL_W-1:pldg_pkg::HALF_W]
                           : r_b[pldg_pkg::HALF_W-1:0];
    assign w_pp = w_ah * w_bh;

    always_comb begin
        case (r_sel)
            2'b00:   w_pp_sh = pldg_pkg::PROD_W'(r_pp);
            2'b11:   w_pp_sh = pldg_pkg::PROD_W'(r_pp) << (2 * pldg_pkg::HALF_W);
            default: w_pp_sh = pldg_pkg::PROD_W'(r_pp) << pldg_pkg::HALF_W;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_pend <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_req.start) begin
                r_busy <= 1'b1;
                r_pend <= 1'b0;
                r_cnt  <= '0;
                r_a    <= i_req.a;
                r_b    <= i_req.b;
                r_acc  <= '0;
            end else if (r_busy) begin
                if (r_pend) begin
                    r_acc <= r_acc + w_pp_sh;
                end
                if (r_cnt == 3'd4) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                    r_pend <= 1'b0;
                end else begin
                    r_pp   <= w_pp;
                    r_sel  <= r_cnt[1:0];
                    r_pend <= 1'b1;
                    r_cnt  <= r_cnt + 3'd1;
                end
            end
        end
    end

    assign o_rsp.busy = r_busy;
    assign o_rsp.done = r_done;
    assign o_rsp.p    = r_acc;

endmodule

// ===== design/piecewise_linear_db_gain_lookup.sv =====
// Sequence: a query runs the segment scan over the n points in use, then the 17-step
//   divider when it interpolates, the decade split, a step per bit of the 12-bit dB
//   remainder with a multiply per set bit, the decade scaling and the output load;
//   a saturating decade goes from the split straight to the output load.
// Throughput: one item at a time; the next is taken once the result is in the output register.
// Reset (synchronous, active low): table holds the 72 factory points, rest zero;
//   points_in_use returns to 72; no result pending.
module piecewise_linear_db_gain_lookup (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_axis_tvalid,
    output logic        o_s_axis_tready,
    input  logic [47:0] i_s_axis_tdata,   // freq[19:0], point_index[26:20], point_gain[42:27]
    input  logic        i_s_axis_tuser,   // mode
    output logic        o_m_axis_tvalid,
    input  logic        i_m_axis_tready,
    output logic [55:0] o_m_axis_tdata,   // gain_linear[31:0], gain_db[47:32],
                                          // clamped[48], saturated[49]
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [7:0]  i_cfg_data        // points_in_use
);

    typedef enum logic [6:0] {
        S_IDLE = 7'b0000001,
        S_SCAN = 7'b0000010,
        S_DIV  = 7'b0000100,
        S_QR   = 7'b0001000,
        S_EXP  = 7'b0010000,
        S_FIN  = 7'b0100000,
        S_OUT  = 7'b1000000
    } t_state;

    localparam int FW = pldg_pkg::FREQ_W;
    localparam int GW = pldg_pkg::GAIN_W;
    localparam int IW = pldg_pkg::IDX_W;

    t_state                         r_state;
    logic [7:0]                     r_pts;
    logic [FW-1:0]                  r_freq;
    logic [IW-1:0]                  r_k;
    logic [IW-1:0]                  r_last;
    logic                           r_below;
    logic                           r_found;
    logic signed [GW-1:0]           r_g0;
    logic [FW-1:0]                  r_f1;
    logic [FW-1:0]                  r_f2;
    logic signed [GW-1:0]           r_g1;
    logic signed [GW-1:0]           r_g2;
    logic signed [GW-1:0]           r_g;
    logic                           r_clamped;
    logic                           r_neg;
    logic [16:0]                    r_dvd;
    logic [FW-1:0]                  r_den;
    logic [FW-1:0]                  r_rem;
    logic [16:0]                    r_quo;
    logic [4:0]                     r_cnt;
    logic signed [5:0]              r_q;
    logic [pldg_pkg::EXP_BITS-1:0]  r_r;
    logic [3:0]                     r_j;
    logic [pldg_pkg::MUL_W-1:0]     r_m;
    logic                           r_wait;
    logic                           r_sat;
    logic [31:0]                    r_lin;
    logic                           r_out_valid;
    logic [55:0]                    r_out_data;

    logic                           w_in_acc;
    logic                           w_wr;
    logic                           w_query;
    logic [IW-1:0]                  w_widx;
    pldg_pkg::t_point               w_wr_point;
    pldg_pkg::t_cell_ctl            w_ctl;
    pldg_pkg::t_point               w_scan [pldg_pkg::MAX_POINTS];
    logic [7:0]                     w_n;
    pldg_pkg::t_mul_req             w_mreq;
    pldg_pkg::t_mul_rsp             w_mrsp;

    // scan step
    pldg_pkg::t_point               w_s0;
    pldg_pkg::t_point               w_s1;
    logic                           w_below;
    logic signed [GW-1:0]           w_g0;
    logic                           w_hit;
    logic                           w_found;
    logic [FW-1:0]                  w_f1;
    logic [FW-1:0]                  w_f2;
    logic signed [GW-1:0]           w_g1;
    logic signed [GW-1:0]           w_g2;
    logic signed [16:0]             w_dg;
    logic [FW-1:0]                  w_df;
    logic signed [37:0]             w_prod;
    logic [36:0]                    w_mag;

    // divider step
    logic [FW:0]                    w_rem2;
    logic                           w_qbit;
    logic [FW-1:0]                  w_rem_n;
    logic [16:0]                    w_quo_n;
    logic signed [17:0]             w_qd;
    logic signed [17:0]             w_gsum;

    // decade split
    logic [16:0]                    w_t;
    logic [33:0]                    w_tq;
    logic [4:0]                     w_qq;
    logic [16:0]                    w_rr;

    // final scaling
    logic [pldg_pkg::MUL_W-1:0]     w_kq;
    logic [pldg_pkg::PROD_W:0]      w_rs;
    logic                           w_hi;

    assign w_in_acc = i_s_axis_tvalid && o_s_axis_tready;
    assign w_wr     = w_in_acc && i_s_axis_tuser;
    assign w_query  = w_in_acc && !i_s_axis_tuser;
    assign w_widx   = i_s_axis_tdata[26:20];
    assign w_wr_point.freq = i_s_axis_tdata[19:0];
    assign w_wr_point.gain = i_s_axis_tdata[42:27];

    assign w_n = (r_pts < 8'd2) ? 8'd2
               : (r_pts > 8'(pldg_pkg::MAX_POINTS)) ? 8'(pldg_pkg::MAX_POINTS) : r_pts;

    assign w_ctl.load  = w_query;
    assign w_ctl.shift = (r_state == S_SCAN) && (r_k != r_last);

    for (genvar gi = 0; gi < pldg_pkg::MAX_POINTS; gi++) begin : g_cell
        pldg_pkg::t_point w_next;
        if (gi == pldg_pkg::MAX_POINTS - 1) begin : g_end
            assign w_next = '0;
        end else begin : g_mid
            assign w_next = w_scan[gi+1];
        end
        pldg_cell u_cell (
            .i_clk      (i_clk),
            .i_rst_n    (i_rst_n),
            .i_init     (pldg_pkg::init_point(gi)),
            .i_wr       (w_wr && (w_widx == IW'(gi))),
            .i_wr_point (w_wr_point),
            .i_ctl      (w_ctl),
            .i_next     (w_next),
            .o_scan     (w_scan[gi])
        );
    end

    pldg_mul u_mul (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (w_mreq),
        .o_rsp   (w_mrsp)
    );

    // cell zero and one hold points k and k+1 of the table
    assign w_s0    = w_scan[0];
    assign w_s1    = w_scan[1];
    assign w_below = (r_k == '0) ? (r_freq < w_s0.freq) : r_below;
    assign w_g0    = (r_k == '0) ? w_s0.gain : r_g0;
    assign w_hit   = !r_found && (r_freq >= w_s0.freq) && (r_freq <= w_s1.freq);
    assign w_found = r_found || w_hit;
    assign w_f1    = r_found ? r_f1 : w_s0.freq;
    assign w_f2    = r_found ? r_f2 : w_s1.freq;
    assign w_g1    = r_found ? r_g1 : w_s0.gain;
    assign w_g2    = r_found ? r_g2 : w_s1.gain;
    assign w_dg    = $signed({w_g2[GW-1], w_g2}) - $signed({w_g1[GW-1], w_g1});
    assign w_df    = r_freq - w_f1;
    assign w_prod  = w_dg * $signed({1'b0, w_df});
    assign w_mag   = w_prod[37] ? 37'(-w_prod) : w_prod[36:0];

    assign w_rem2  = {r_rem, r_dvd[16]};
    assign w_qbit  = (w_rem2 >= {1'b0, r_den});
    assign w_rem_n = w_qbit ? FW'(w_rem2 - {1'b0, r_den}) : w_rem2[FW-1:0];
    assign w_quo_n = {r_quo[15:0], w_qbit};
    // floor division: round the magnitude up when the quotient is negative
    assign w_qd    = r_neg ? -($signed({1'b0, w_quo_n}) + 18'(w_rem_n != '0))
                           : $signed({1'b0, w_quo_n});
    assign w_gsum  = $signed({{2{r_g1[GW-1]}}, r_g1}) + w_qd;

    assign w_t  = 17'($signed({r_g[GW-1], r_g}) + 18'sd33280);
    assign w_tq = 34'(w_t) * 34'(pldg_pkg::Q_RECIP);
    assign w_qq = w_tq[pldg_pkg::Q_SHIFT +: 5];
    assign w_rr = w_t - ((17'(w_qq) << 11) + (17'(w_qq) << 9));

    assign w_kq = r_q[5] ? pldg_pkg::RECIP_DEC[4'(~r_q)] : pldg_pkg::POW10[r_q[2:0]];
    assign w_rs = r_q[5]
        ? (pldg_pkg::PROD_W+1)'(w_mrsp.p) + ((pldg_pkg::PROD_W+1)'(1)
            << (pldg_pkg::FRAC_W + pldg_pkg::RECIP_FRAC_W - pldg_pkg::OUT_FRAC_W - 1))
        : (pldg_pkg::PROD_W+1)'(w_mrsp.p) + ((pldg_pkg::PROD_W+1)'(1)
            << (pldg_pkg::FRAC_W - pldg_pkg::OUT_FRAC_W - 1));
    assign w_hi = (w_rs[pldg_pkg::PROD_W:pldg_pkg::FRAC_W-pldg_pkg::OUT_FRAC_W+32] != '0);

    always_comb begin
        w_mreq = '0;
        if (r_state == S_EXP) begin
            if (r_j == 4'(pldg_pkg::EXP_BITS)) begin
                w_mreq.start = 1'b1;
                w_mreq.a     = r_m;
                w_mreq.b     = w_kq;
            end else if (!r_wait && r_r[r_j]) begin
                w_mreq.start = 1'b1;
                w_mreq.a     = r_m;
                w_mreq.b     = pldg_pkg::EXP_FACT[r_j];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_pts   <= 8'd72;
            r_wait  <= 1'b0;
        end else begin
            if (i_cfg_valid && o_cfg_ready) begin
                r_pts <= i_cfg_data;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (w_query) begin
                        r_freq  <= i_s_axis_tdata[19:0];
                        r_k     <= '0;
                        r_found <= 1'b0;
                        r_last  <= IW'(w_n - 8'd2);
                        r_state <= S_SCAN;
                    end
                end
                S_SCAN: begin
                    if (r_k == r_last) begin
                        r_g1 <= w_g1;
                        if (w_below) begin
                            r_g <= w_g0;  r_clamped <= 1'b1;  r_state <= S_QR;
                        end else if (r_freq > w_s1.freq) begin
                            r_g <= w_s1.gain;  r_clamped <= 1'b1;  r_state <= S_QR;
                        end else if (!w_found) begin
                            r_g <= w_s1.gain;  r_clamped <= 1'b1;  r_state <= S_QR;
                        end else if (w_f1 == w_f2) begin
                            r_g <= w_g1;  r_clamped <= 1'b0;  r_state <= S_QR;
                        end else begin
                            r_neg   <= w_prod[37];
                            r_rem   <= w_mag[36:17];
                            r_dvd   <= w_mag[16:0];
                            r_den   <= w_f2 - w_f1;
                            r_quo   <= '0;
                            r_cnt   <= '0;
                            r_state <= S_DIV;
                        end
                    end else begin
                        if (r_k == '0) begin
                            r_below <= w_below;
                            r_g0    <= w_g0;
                        end
                        if (w_hit) begin
                            r_found <= 1'b1;
                            r_f1 <= w_s0.freq;  r_f2 <= w_s1.freq;
                            r_g1 <= w_s0.gain;  r_g2 <= w_s1.gain;
                        end
                        r_k <= r_k + 1'b1;
                    end
                end
                S_DIV: begin
                    r_rem <= w_rem_n;
                    r_quo <= w_quo_n;
                    r_dvd <= {r_dvd[15:0], 1'b0};
                    r_cnt <= r_cnt + 5'd1;
                    if (r_cnt == 5'(pldg_pkg::DIV_STEPS - 1)) begin
                        r_g       <= w_gsum[GW-1:0];
                        r_clamped <= 1'b0;
                        r_state   <= S_QR;
                    end
                end
                S_QR: begin
                    r_q <= $signed({1'b0, w_qq}) - 6'sd13;
                    r_r <= w_rr[pldg_pkg::EXP_BITS-1:0];
                    r_j <= '0;
                    r_m <= pldg_pkg::MUL_W'(1) << pldg_pkg::FRAC_W;
                    if (w_qq >= 5'(pldg_pkg::Q_SAT)) begin
                        r_sat   <= 1'b1;
                        r_lin   <= '1;
                        r_state <= S_OUT;
                    end else begin
                        r_state <= S_EXP;
                    end
                end
                S_EXP: begin
                    if (r_j == 4'(pldg_pkg::EXP_BITS)) begin
                        r_wait  <= 1'b1;
                        r_state <= S_FIN;
                    end else if (r_wait) begin
                        if (w_mrsp.done) begin
                            r_m    <= w_mrsp.p[pldg_pkg::FRAC_W +: pldg_pkg::MUL_W];
                            r_wait <= 1'b0;
                            r_j    <= r_j + 4'd1;
                        end
                    end else if (r_r[r_j]) begin
                        r_wait <= 1'b1;
                    end else begin
                        r_j <= r_j + 4'd1;
                    end
                end
                S_FIN: begin
                    if (w_mrsp.done) begin
                        r_wait <= 1'b0;
                        if (r_q[5]) begin
                            r_sat <= 1'b0;
                            r_lin <= 32'(w_rs[pldg_pkg::PROD_W:
                                pldg_pkg::FRAC_W+pldg_pkg::RECIP_FRAC_W-pldg_pkg::OUT_FRAC_W]);
                        end else begin
                            r_sat <= w_hi;
                            r_lin <= w_hi ? '1
                                : w_rs[pldg_pkg::FRAC_W-pldg_pkg::OUT_FRAC_W +: 32];
                        end
                        r_state <= S_OUT;
                    end
                end
                S_OUT: begin
                    if (!r_out_valid || i_m_axis_tready) begin
                        r_state <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    // output register: load the finished result once the previous transfer has gone
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if ((r_state == S_OUT) && (!r_out_valid || i_m_axis_tready)) begin
            r_out_valid <= 1'b1;
            r_out_data  <= {6'b0, r_sat, r_clamped, r_g, r_lin};
        end else if (i_m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    assign o_s_axis_tready = (r_state == S_IDLE);
    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = r_out_data;
    assign o_cfg_ready     = 1'b1;

    a_sat_all_ones: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_axis_tvalid && o_m_axis_tdata[49]) |-> (o_m_axis_tdata[31:0] == 32'hFFFFFFFF))
        else $error("saturated result without clipped linear gain");

    a_scan_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_SCAN) |-> (r_k <= r_last))
        else $error("segment scan ran past the last point in use");

    a_mul_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_mreq.start |-> !w_mrsp.busy)
        else $error("multiplier started while busy");

    a_mul_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_mreq.start |=> ##5 w_mrsp.done)
        else $error("multiplier result not ready after six cycles");

endmodule
